### rtl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the polyphonic voice allocator / ADSR core.
// ----------------------------------------------------------------------------
package pva_pkg;

    // Voice table size default and report limit per tick
    localparam int DEF_VOICES = 8;
    localparam int MAX_REPORT = 8;

    // Field widths
    localparam int LVL_W   = 16;
    localparam int CNT_W   = 24;
    localparam int STAMP_W = 32;
    localparam int NOTE_W  = 7;
    localparam int QUO_W   = 16;
    localparam int NUM_W   = LVL_W + CNT_W;

    // Q1.15 full scale
    localparam logic [LVL_W-1:0] FULL_SCALE = 16'd32768;

    // Register reset values
    localparam logic [CNT_W-1:0] RST_ATTACK  = 24'd480;
    localparam logic [CNT_W-1:0] RST_DECAY   = 24'd4800;
    localparam logic [LVL_W-1:0] RST_SUSTAIN = 16'd22938;
    localparam logic [CNT_W-1:0] RST_RELEASE = 24'd9600;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } reg_idx_t;

    // Operation codes
    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_TICK     = 2'd2
    } op_t;

    // Envelope phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_STEP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

### rtl/pva_div.sv
// ----------------------------------------------------------------------------
// pva_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits QUO_W bits (numerator < divisor * 2^QUO_W).
// ----------------------------------------------------------------------------
module pva_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pva_pkg::NUM_W-1:0]  numer,
    input  logic [pva_pkg::CNT_W-1:0]  denom,
    output logic                       done,
    output logic [pva_pkg::QUO_W-1:0]  quot
);

    logic [pva_pkg::CNT_W:0]   rem_reg;
    logic [pva_pkg::QUO_W-1:0] lo_reg;
    logic [pva_pkg::QUO_W-1:0] quot_reg;
    logic [4:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [pva_pkg::CNT_W:0]   trial;
    logic                      fit;

    // shift in next numerator bit and try subtract
    assign trial = {rem_reg[pva_pkg::CNT_W-1:0], lo_reg[pva_pkg::QUO_W-1]};
    assign fit   = trial >= {1'b0, denom};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(pva_pkg::QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, numer[pva_pkg::NUM_W-1:pva_pkg::QUO_W]};
            lo_reg   <= numer[pva_pkg::QUO_W-1:0];
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fit ? (trial - {1'b0, denom}) : trial;
            lo_reg   <= {lo_reg[pva_pkg::QUO_W-2:0], 1'b0};
            quot_reg <= {quot_reg[pva_pkg::QUO_W-2:0], fit};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### rtl/polyphonic_voice_allocator_adsr_core.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_adsr_core
// Voice table with note-on/note-off allocation and linear ADSR envelopes.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_stall stays high until its last result word
// has been loaded into the output register and, for a tick, every voice has
// been stepped. Note-on and note-off scan the table one voice per cycle, then
// update the chosen voice and report it. A tick steps every voice in turn; a
// voice inside a ramp goes through the shared multiplier and the bit-serial
// divider, and any output stall holds the tick back. A tick reports results
// for voices 0 to 7 only; a note word reports its chosen voice.
module polyphonic_voice_allocator_adsr_core
#(
    parameter int N_VOICES = pva_pkg::DEF_VOICES
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [6:0]  note_number,
    input  logic [6:0]  note_velocity,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  voice_index,
    output logic        found,
    output logic [2:0]  env_phase,
    output logic [15:0] env_level,
    output logic [6:0]  voice_note,
    output logic [6:0]  voice_velocity,
    output logic        last
);

    localparam int VW   = (N_VOICES > 1) ? $clog2(N_VOICES) : 1;
    localparam int NREP = (N_VOICES < pva_pkg::MAX_REPORT) ? N_VOICES
                                                           : pva_pkg::MAX_REPORT;
    localparam logic [VW:0] LAST_V = (VW+1)'(N_VOICES - 1);
    localparam logic [VW:0] LAST_R = (VW+1)'(NREP - 1);

    // configuration registers
    logic [23:0] attack_reg, decay_reg, release_reg;
    logic [15:0] sustain_reg;
    logic [15:0] sus_sat;

    // voice table
    pva_pkg::phase_t phase_reg [N_VOICES];
    logic [15:0]     level_reg [N_VOICES];
    logic [23:0]     count_reg [N_VOICES];
    logic [15:0]     start_reg [N_VOICES];
    logic [6:0]      key_reg   [N_VOICES];
    logic [6:0]      vel_reg   [N_VOICES];
    logic [31:0]     stamp_reg [N_VOICES];
    logic [31:0]     next_stamp_reg;

    // sequencer
    pva_pkg::state_t state_reg, state_next;
    logic [VW:0]     idx_reg;
    logic [VW-1:0]   vi;
    logic [1:0]      op_reg;
    logic [6:0]      note_reg, nvel_reg;

    // search candidates
    logic            ca_ok_reg, cb_ok_reg, cc_ok_reg;
    logic [VW-1:0]   ca_sel_reg, cb_sel_reg, cc_sel_reg;
    logic [31:0]     cb_val_reg, cc_val_reg;

    // report selection
    logic [VW-1:0]   rpt_sel_reg;
    logic            rpt_found_reg, rpt_zero_reg, rpt_last_reg;

    // arithmetic
    logic [15:0]     mul_a_reg;
    logic [23:0]     div_d_reg;
    logic [39:0]     prod_reg;
    logic            div_start, div_done;
    logic [15:0]     div_q;

    // step decision for the current voice
    logic            step_end;
    logic            is_held, is_key;
    logic            scan_last, out_free;
    logic            after_step_emit;

    // output register
    logic            out_valid_reg;
    logic [2:0]      oidx_reg, ophase_reg;
    logic            ofound_reg, olast_reg;
    logic [15:0]     olevel_reg;
    logic [6:0]      onote_reg, ovel_reg;
    logic [VW+2:0]   rpt_wide;

    assign vi        = idx_reg[VW-1:0];
    assign sus_sat   = (sustain_reg > pva_pkg::FULL_SCALE) ? pva_pkg::FULL_SCALE
                                                           : sustain_reg;
    assign scan_last = (idx_reg == LAST_V);
    assign out_free  = !out_valid_reg || !out_stall;
    assign after_step_emit = (idx_reg <= LAST_R);
    assign is_key    = (key_reg[vi] == note_reg);
    assign is_held   = is_key && (phase_reg[vi] != pva_pkg::PH_IDLE)
                       && (phase_reg[vi] != pva_pkg::PH_RELEASE);
    assign in_stall  = (state_reg != pva_pkg::ST_IDLE);
    assign div_start = (state_reg == pva_pkg::ST_DIV_GO);

    // does the current segment end on this tick
    always_comb
    begin
        case (phase_reg[vi])
            pva_pkg::PH_ATTACK:  step_end = (attack_reg == '0) ||
                                            (count_reg[vi] >= attack_reg);
            pva_pkg::PH_DECAY:   step_end = (decay_reg == '0) ||
                                            (count_reg[vi] >= decay_reg);
            pva_pkg::PH_RELEASE: step_end = (release_reg == '0) ||
                                            (count_reg[vi] >= release_reg);
            default:             step_end = 1'b1;
        endcase
    end

    // shared divider
    pva_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (prod_reg),
        .denom (div_d_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (operation)
                        pva_pkg::OP_NOTE_ON,
                        pva_pkg::OP_NOTE_OFF: state_next = pva_pkg::ST_SCAN;
                        pva_pkg::OP_TICK:     state_next = pva_pkg::ST_STEP;
                        default:              state_next = pva_pkg::ST_IDLE;
                    endcase
                end
            end
            pva_pkg::ST_SCAN:
            begin
                if (scan_last)
                    state_next = pva_pkg::ST_APPLY;
            end
            pva_pkg::ST_APPLY:  state_next = pva_pkg::ST_EMIT;
            pva_pkg::ST_STEP:
            begin
                if (!step_end)
                    state_next = pva_pkg::ST_MUL;
                else if (after_step_emit)
                    state_next = pva_pkg::ST_EMIT;
                else if (scan_last)
                    state_next = pva_pkg::ST_IDLE;
            end
            pva_pkg::ST_MUL:    state_next = pva_pkg::ST_DIV_GO;
            pva_pkg::ST_DIV_GO: state_next = pva_pkg::ST_DIV;
            pva_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (after_step_emit)
                        state_next = pva_pkg::ST_EMIT;
                    else if (scan_last)
                        state_next = pva_pkg::ST_IDLE;
                    else
                        state_next = pva_pkg::ST_STEP;
                end
            end
            pva_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    if (op_reg == pva_pkg::OP_TICK && !scan_last)
                        state_next = pva_pkg::ST_STEP;
                    else
                        state_next = pva_pkg::ST_IDLE;
                end
            end
            default: state_next = pva_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pva_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= pva_pkg::RST_ATTACK;
            decay_reg   <= pva_pkg::RST_DECAY;
            sustain_reg <= pva_pkg::RST_SUSTAIN;
            release_reg <= pva_pkg::RST_RELEASE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pva_pkg::REG_ATTACK:  attack_reg  <= cfg_data;
                pva_pkg::REG_DECAY:   decay_reg   <= cfg_data;
                pva_pkg::REG_SUSTAIN: sustain_reg <= cfg_data[15:0];
                pva_pkg::REG_RELEASE: release_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer datapath and voice table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_VOICES; i++)
            begin
                phase_reg[i] <= pva_pkg::PH_IDLE;
                level_reg[i] <= '0;
                count_reg[i] <= '0;
                start_reg[i] <= '0;
                key_reg[i]   <= '0;
                vel_reg[i]   <= '0;
                stamp_reg[i] <= '0;
            end
            next_stamp_reg <= '0;
            idx_reg        <= '0;
            op_reg         <= '0;
            note_reg       <= '0;
            nvel_reg       <= '0;
            ca_ok_reg      <= 1'b0;
            cb_ok_reg      <= 1'b0;
            cc_ok_reg      <= 1'b0;
            ca_sel_reg     <= '0;
            cb_sel_reg     <= '0;
            cc_sel_reg     <= '0;
            cb_val_reg     <= '0;
            cc_val_reg     <= '0;
            rpt_sel_reg    <= '0;
            rpt_found_reg  <= 1'b0;
            rpt_zero_reg   <= 1'b0;
            rpt_last_reg   <= 1'b0;
            mul_a_reg      <= '0;
            div_d_reg      <= '0;
            prod_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                // capture the word
                pva_pkg::ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= operation;
                        note_reg  <= note_number;
                        nvel_reg  <= note_velocity;
                        idx_reg   <= '0;
                        ca_ok_reg <= 1'b0;
                        cb_ok_reg <= 1'b0;
                        cc_ok_reg <= 1'b0;
                    end
                end

                // one voice per cycle search
                pva_pkg::ST_SCAN:
                begin
                    if (op_reg == pva_pkg::OP_NOTE_ON)
                    begin
                        // first idle voice
                        if (!ca_ok_reg && phase_reg[vi] == pva_pkg::PH_IDLE)
                        begin
                            ca_ok_reg  <= 1'b1;
                            ca_sel_reg <= vi;
                        end
                        // lowest releasing level
                        if (phase_reg[vi] == pva_pkg::PH_RELEASE &&
                            (!cb_ok_reg || {16'd0, level_reg[vi]} < cb_val_reg))
                        begin
                            cb_ok_reg  <= 1'b1;
                            cb_sel_reg <= vi;
                            cb_val_reg <= {16'd0, level_reg[vi]};
                        end
                        // oldest stamp
                        if (!cc_ok_reg || stamp_reg[vi] < cc_val_reg)
                        begin
                            cc_ok_reg  <= 1'b1;
                            cc_sel_reg <= vi;
                            cc_val_reg <= stamp_reg[vi];
                        end
                    end
                    else
                    begin
                        // oldest held voice with the key
                        if (is_held && (!cb_ok_reg || stamp_reg[vi] < cb_val_reg))
                        begin
                            cb_ok_reg  <= 1'b1;
                            cb_sel_reg <= vi;
                            cb_val_reg <= stamp_reg[vi];
                        end
                        // first sounding voice with the key
                        if (!ca_ok_reg && is_key && phase_reg[vi] != pva_pkg::PH_IDLE)
                        begin
                            ca_ok_reg  <= 1'b1;
                            ca_sel_reg <= vi;
                        end
                    end
                    if (!scan_last)
                        idx_reg <= idx_reg + 1'b1;
                end

                // update the chosen voice
                pva_pkg::ST_APPLY:
                begin
                    rpt_last_reg <= 1'b1;
                    if (op_reg == pva_pkg::OP_NOTE_ON)
                    begin
                        logic [VW-1:0] s;
                        s = ca_ok_reg ? ca_sel_reg : (cb_ok_reg ? cb_sel_reg : cc_sel_reg);
                        key_reg[s]     <= note_reg;
                        vel_reg[s]     <= nvel_reg;
                        stamp_reg[s]   <= next_stamp_reg;
                        next_stamp_reg <= next_stamp_reg + 32'd1;
                        phase_reg[s]   <= pva_pkg::PH_ATTACK;
                        level_reg[s]   <= '0;
                        count_reg[s]   <= '0;
                        start_reg[s]   <= '0;
                        rpt_sel_reg    <= s;
                        rpt_found_reg  <= 1'b1;
                        rpt_zero_reg   <= 1'b0;
                    end
                    else
                    begin
                        logic [VW-1:0] s;
                        s = cb_ok_reg ? cb_sel_reg : ca_sel_reg;
                        rpt_sel_reg   <= s;
                        rpt_found_reg <= cb_ok_reg || ca_ok_reg;
                        rpt_zero_reg  <= !(cb_ok_reg || ca_ok_reg);
                        if (cb_ok_reg || ca_ok_reg)
                        begin
                            phase_reg[s] <= pva_pkg::PH_RELEASE;
                            count_reg[s] <= '0;
                            start_reg[s] <= level_reg[s];
                        end
                    end
                end

                // envelope step: finish a segment or set up the ramp
                pva_pkg::ST_STEP:
                begin
                    rpt_sel_reg   <= vi;
                    rpt_found_reg <= 1'b0;
                    rpt_zero_reg  <= 1'b0;
                    rpt_last_reg  <= (idx_reg == LAST_R);
                    case (phase_reg[vi])
                        pva_pkg::PH_ATTACK:
                        begin
                            mul_a_reg <= pva_pkg::FULL_SCALE;
                            div_d_reg <= attack_reg;
                            if (step_end)
                            begin
                                level_reg[vi] <= pva_pkg::FULL_SCALE;
                                phase_reg[vi] <= pva_pkg::PH_DECAY;
                                count_reg[vi] <= '0;
                            end
                        end
                        pva_pkg::PH_DECAY:
                        begin
                            mul_a_reg <= pva_pkg::FULL_SCALE - sus_sat;
                            div_d_reg <= decay_reg;
                            if (step_end)
                            begin
                                level_reg[vi] <= sus_sat;
                                phase_reg[vi] <= pva_pkg::PH_SUSTAIN;
                            end
                        end
                        pva_pkg::PH_SUSTAIN:
                            level_reg[vi] <= sus_sat;
                        pva_pkg::PH_RELEASE:
                        begin
                            mul_a_reg <= start_reg[vi];
                            div_d_reg <= release_reg;
                            if (step_end)
                            begin
                                level_reg[vi] <= '0;
                                phase_reg[vi] <= pva_pkg::PH_IDLE;
                            end
                        end
                        default:
                        begin
                            phase_reg[vi] <= pva_pkg::PH_IDLE;
                            level_reg[vi] <= '0;
                        end
                    endcase
                    if (step_end && !after_step_emit && !scan_last)
                        idx_reg <= idx_reg + 1'b1;
                end

                // product for the ramp
                pva_pkg::ST_MUL:
                    prod_reg <= 40'(mul_a_reg) * 40'(count_reg[vi]);

                pva_pkg::ST_DIV_GO: ;

                // write back the interpolated level
                pva_pkg::ST_DIV:
                begin
                    if (div_done)
                    begin
                        case (phase_reg[vi])
                            pva_pkg::PH_ATTACK:  level_reg[vi] <= div_q;
                            pva_pkg::PH_DECAY:   level_reg[vi] <= pva_pkg::FULL_SCALE - div_q;
                            default:             level_reg[vi] <= start_reg[vi] - div_q;
                        endcase
                        count_reg[vi] <= count_reg[vi] + 24'd1;
                        if (!after_step_emit && !scan_last)
                            idx_reg <= idx_reg + 1'b1;
                    end
                end

                // hand off to the output register
                pva_pkg::ST_EMIT:
                begin
                    if (out_free && op_reg == pva_pkg::OP_TICK && !scan_last)
                        idx_reg <= idx_reg + 1'b1;
                end

                default: ;
            endcase
        end
    end

    // output register
    assign rpt_wide = {3'd0, rpt_sel_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == pva_pkg::ST_EMIT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == pva_pkg::ST_EMIT && out_free)
        begin
            ofound_reg <= rpt_found_reg;
            olast_reg  <= rpt_last_reg;
            if (rpt_zero_reg)
            begin
                oidx_reg   <= '0;
                ophase_reg <= pva_pkg::PH_IDLE;
                olevel_reg <= '0;
                onote_reg  <= '0;
                ovel_reg   <= '0;
            end
            else
            begin
                oidx_reg   <= rpt_wide[2:0];
                ophase_reg <= phase_reg[rpt_sel_reg];
                olevel_reg <= level_reg[rpt_sel_reg];
                if (phase_reg[rpt_sel_reg] == pva_pkg::PH_IDLE)
                begin
                    onote_reg <= '0;
                    ovel_reg  <= '0;
                end
                else
                begin
                    onote_reg <= key_reg[rpt_sel_reg];
                    ovel_reg  <= vel_reg[rpt_sel_reg];
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign voice_index    = oidx_reg;
    assign found          = ofound_reg;
    assign env_phase      = ophase_reg;
    assign env_level      = olevel_reg;
    assign voice_note     = onote_reg;
    assign voice_velocity = ovel_reg;
    assign last           = olast_reg;

endmodule
